// ===== hdl/tfr_pkg.sv =====
`default_nettype none
package tfr_pkg;

  // Pattern selection codes held in the mode register
  localparam logic [2:0] MODE_DIGITS = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_IPV4   = 3'd2;
  localparam logic [2:0] MODE_DATE   = 3'd3;
  localparam logic [2:0] MODE_FLIGHT = 3'd4;

  localparam int unsigned ModeWidth = 3;

  // Pattern limits
  localparam logic [9:0] OCTET_MAX    = 10'd255;
  localparam logic [2:0] OCTET_DIGITS = 3'd3;
  localparam logic [3:0] DATE_LEN     = 4'd10;
  localparam logic [3:0] DATE_DASH_A  = 4'd4;
  localparam logic [3:0] DATE_DASH_B  = 4'd7;
  localparam logic [7:0] CHAR_DOT     = 8'h2e;
  localparam logic [7:0] CHAR_DASH    = 8'h2d;

  // Per-token progress carried from one character to the next
  typedef struct packed {
    logic [3:0] char_position;
    logic [2:0] run_length;
    logic [9:0] octet_value;
    logic [2:0] group_count;
    logic       in_digit_phase;
    logic       failed;
  } tok_state_t;

  localparam tok_state_t TOK_CLEAR = '{
    char_position:  4'd0,
    run_length:     3'd0,
    octet_value:    10'd0,
    group_count:    3'd0,
    in_digit_phase: 1'b0,
    failed:         1'b0
  };

endpackage
`default_nettype wire

// ===== hdl/tfr_step.sv =====
`default_nettype none
module tfr_step #(
  parameter int unsigned ModeWidth = tfr_pkg::ModeWidth
) (
  input  wire logic [ModeWidth-1:0] mode_i,
  input  wire tfr_pkg::tok_state_t  tok_i,
  input  wire logic [7:0]           char_code_i,
  output tfr_pkg::tok_state_t       tok_o,
  output logic                      matched_o
);

  logic       is_dig;
  logic       is_up;
  logic       is_alp;
  logic [3:0] digit;
  logic [13:0] oct_acc;
  logic [2:0] run_inc;

  // Classify the character
  assign is_dig = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
  assign is_up  = (char_code_i >= 8'h41) && (char_code_i <= 8'h5a);
  assign is_alp = is_up || ((char_code_i >= 8'h61) && (char_code_i <= 8'h7a));
  assign digit  = 4'(char_code_i - 8'h30);

  // Octet accumulate and saturating run count
  assign oct_acc = {4'd0, tok_i.octet_value} * 14'd10 + {10'd0, digit};
  assign run_inc = (tok_i.run_length == 3'd7) ? 3'd7 : tok_i.run_length + 3'd1;

  // Advance the token state by one character
  always_comb begin
    tok_o = tok_i;
    if (tok_i.char_position != 4'd15) begin
      tok_o.char_position = tok_i.char_position + 4'd1;
    end
    case (mode_i)
      tfr_pkg::MODE_DIGITS: begin
        if (!is_dig) tok_o.failed = 1'b1;
      end
      tfr_pkg::MODE_IDENT: begin
        if (tok_i.char_position == 4'd0) begin
          if (!is_alp) tok_o.failed = 1'b1;
        end else if (!(is_alp || is_dig)) begin
          tok_o.failed = 1'b1;
        end
      end
      tfr_pkg::MODE_IPV4: begin
        if (is_dig) begin
          if (tok_i.run_length >= tfr_pkg::OCTET_DIGITS) begin
            tok_o.failed = 1'b1;
          end else begin
            tok_o.octet_value = (oct_acc > 14'd1023) ? 10'd1023 : oct_acc[9:0];
          end
          tok_o.run_length = run_inc;
        end else if (char_code_i == tfr_pkg::CHAR_DOT) begin
          if ((tok_i.run_length == 3'd0) || (tok_i.octet_value > tfr_pkg::OCTET_MAX) ||
              (tok_i.group_count >= 3'd3)) begin
            tok_o.failed = 1'b1;
          end
          if (tok_i.group_count != 3'd7) tok_o.group_count = tok_i.group_count + 3'd1;
          tok_o.run_length  = 3'd0;
          tok_o.octet_value = 10'd0;
        end else begin
          tok_o.failed = 1'b1;
        end
      end
      tfr_pkg::MODE_DATE: begin
        if (tok_i.char_position >= tfr_pkg::DATE_LEN) begin
          tok_o.failed = 1'b1;
        end else if ((tok_i.char_position == tfr_pkg::DATE_DASH_A) ||
                     (tok_i.char_position == tfr_pkg::DATE_DASH_B)) begin
          if (char_code_i != tfr_pkg::CHAR_DASH) tok_o.failed = 1'b1;
        end else if (!is_dig) begin
          tok_o.failed = 1'b1;
        end
      end
      tfr_pkg::MODE_FLIGHT: begin
        if (is_up) begin
          if (tok_i.in_digit_phase || (run_inc > 3'd3)) tok_o.failed = 1'b1;
          tok_o.run_length = run_inc;
        end else if (is_dig) begin
          if (!tok_i.in_digit_phase) begin
            if ((tok_i.run_length < 3'd2) || (tok_i.run_length > 3'd3)) tok_o.failed = 1'b1;
            tok_o.in_digit_phase = 1'b1;
            tok_o.run_length     = 3'd1;
          end else begin
            if (run_inc > 3'd4) tok_o.failed = 1'b1;
            tok_o.run_length = run_inc;
          end
        end else begin
          tok_o.failed = 1'b1;
        end
      end
      default: begin
        tok_o.failed = 1'b1;
      end
    endcase
  end

  // Judge the token as it stands after this character
  always_comb begin
    matched_o = 1'b0;
    case (mode_i)
      tfr_pkg::MODE_DIGITS, tfr_pkg::MODE_IDENT: begin
        matched_o = 1'b1;
      end
      tfr_pkg::MODE_IPV4: begin
        matched_o = (tok_o.run_length != 3'd0) && (tok_o.octet_value <= tfr_pkg::OCTET_MAX) &&
                    (tok_o.group_count == 3'd3);
      end
      tfr_pkg::MODE_DATE: begin
        matched_o = (tok_o.char_position == tfr_pkg::DATE_LEN);
      end
      tfr_pkg::MODE_FLIGHT: begin
        matched_o = tok_o.in_digit_phase && (tok_o.run_length >= 3'd2) &&
                    (tok_o.run_length <= 3'd4);
      end
      default: begin
        matched_o = 1'b0;
      end
    endcase
    if (tok_o.failed) matched_o = 1'b0;
  end

endmodule
`default_nettype wire

// ===== hdl/token_format_recognizer_core.sv =====
`default_nettype none
// Streaming token checker: one character per request, one match/no-match result when the
// request marked last arrives. Each character is captured in an input register and the
// token state advances through one pass of character logic in the next cycle, so a new
// character is taken every cycle while no last character waits; a result is written to
// the output register as its last character is processed and held there while stalled.
// A last character waits in the input register while a stalled result fills the output
// register, which holds off the next request.
// A request flagged as having no character is dropped unless it is last, in which case
// it yields no-match. Writing the mode register selects the pattern (0 digits,
// 1 identifier, 2 dotted IPv4, 3 date dddd-dd-dd, 4 flight code; others never match)
// and starts a new token; write it only while the block is idle.
module token_format_recognizer_core #(
  parameter int unsigned ModeWidth = tfr_pkg::ModeWidth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [ModeWidth-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           char_code_i,
  input  wire logic                 last_char_i,
  input  wire logic                 no_char_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      matched_o
);

  logic [ModeWidth-1:0] mode_q;
  tfr_pkg::tok_state_t  tok_q, tok_d, tok_step;
  logic                 step_match;
  logic                 in_valid_q;
  logic [7:0]           char_q;
  logic                 last_q;
  logic                 none_q;
  logic                 out_valid_q;
  logic                 matched_q;
  logic                 out_free;
  logic                 proc;
  logic                 in_take;

  tfr_step #(
    .ModeWidth (ModeWidth)
  ) u_step (
    .mode_i      (mode_q),
    .tok_i       (tok_q),
    .char_code_i (char_q),
    .tok_o       (tok_step),
    .matched_o   (step_match)
  );

  // Handshake: a last character needs room in the output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  // Next token state: clear on mode write and at end of token
  always_comb begin
    tok_d = tok_q;
    if (cfg_we_i) begin
      tok_d = tfr_pkg::TOK_CLEAR;
    end else if (proc) begin
      if (last_q) begin
        tok_d = tfr_pkg::TOK_CLEAR;
      end else if (!none_q) begin
        tok_d = tok_step;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      tok_q       <= tfr_pkg::TOK_CLEAR;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      tok_q <= tok_d;
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc && last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture the request, hold the result
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
      none_q <= no_char_i;
    end
    if (proc && last_q) begin
      matched_q <= !none_q && step_match;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule
`default_nettype wire

// ===== verif/tfr_match_checker.sv =====
module tfr_match_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tfr_pkg::ModeWidth-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [7:0]                    char_code_i,
  input  logic                          last_char_i,
  input  logic                          no_char_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          matched_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  logic [2:0]          cur_mode;
  tfr_pkg::tok_state_t tok;
  logic                verdict_due_q[$];
  int                  mismatches;

  function automatic logic char_is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic char_is_cap(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic char_is_letter(input logic [7:0] c);
    return char_is_cap(c) || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [2:0] bump_count(input logic [2:0] n);
    return (n < 3'd7) ? n + 3'd1 : n;
  endfunction

  // Advance the token progress by one character under pattern m
  function automatic tfr_pkg::tok_state_t scan_char(input tfr_pkg::tok_state_t s,
                                                    input logic [2:0] m,
                                                    input logic [7:0] c);
    tfr_pkg::tok_state_t n;
    logic [7:0] digit_val;
    int         v;
    n = s;
    digit_val = c - "0";
    case (m)
      tfr_pkg::MODE_DIGITS: begin
        if (!char_is_num(c)) n.failed = 1'b1;
      end
      tfr_pkg::MODE_IDENT: begin
        if (s.char_position == 4'd0) begin
          if (!char_is_letter(c)) n.failed = 1'b1;
        end else if (!(char_is_letter(c) || char_is_num(c))) begin
          n.failed = 1'b1;
        end
      end
      tfr_pkg::MODE_IPV4: begin
        if (char_is_num(c)) begin
          if (s.run_length >= tfr_pkg::OCTET_DIGITS) begin
            n.failed = 1'b1;
          end else begin
            v = s.octet_value * 10 + digit_val;
            n.octet_value = (v > 1023) ? 10'd1023 : v[9:0];
          end
          n.run_length = bump_count(s.run_length);
        end else if (c == tfr_pkg::CHAR_DOT) begin
          if (s.run_length == 3'd0 || s.octet_value > tfr_pkg::OCTET_MAX ||
              s.group_count >= 3'd3)
            n.failed = 1'b1;
          n.group_count = bump_count(s.group_count);
          n.run_length  = 3'd0;
          n.octet_value = 10'd0;
        end else begin
          n.failed = 1'b1;
        end
      end
      tfr_pkg::MODE_DATE: begin
        if (s.char_position >= tfr_pkg::DATE_LEN) begin
          n.failed = 1'b1;
        end else if (s.char_position == tfr_pkg::DATE_DASH_A ||
                     s.char_position == tfr_pkg::DATE_DASH_B) begin
          if (c != tfr_pkg::CHAR_DASH) n.failed = 1'b1;
        end else if (!char_is_num(c)) begin
          n.failed = 1'b1;
        end
      end
      tfr_pkg::MODE_FLIGHT: begin
        if (char_is_cap(c)) begin
          if (s.in_digit_phase) n.failed = 1'b1;
          n.run_length = bump_count(s.run_length);
          if (n.run_length > 3'd3) n.failed = 1'b1;
        end else if (char_is_num(c)) begin
          if (!s.in_digit_phase) begin
            if (s.run_length < 3'd2 || s.run_length > 3'd3) n.failed = 1'b1;
            n.in_digit_phase = 1'b1;
            n.run_length     = 3'd1;
          end else begin
            n.run_length = bump_count(s.run_length);
            if (n.run_length > 3'd4) n.failed = 1'b1;
          end
        end else begin
          n.failed = 1'b1;
        end
      end
      default: n.failed = 1'b1;
    endcase
    if (s.char_position < 4'd15) n.char_position = s.char_position + 4'd1;
    return n;
  endfunction

  // Decide whether the finished token fits pattern m
  function automatic logic token_matches(input tfr_pkg::tok_state_t s, input logic [2:0] m);
    if (s.failed) return 1'b0;
    case (m)
      tfr_pkg::MODE_DIGITS, tfr_pkg::MODE_IDENT: return 1'b1;
      tfr_pkg::MODE_IPV4:
        return s.run_length >= 3'd1 && s.octet_value <= tfr_pkg::OCTET_MAX &&
               s.group_count == 3'd3;
      tfr_pkg::MODE_DATE: return s.char_position == tfr_pkg::DATE_LEN;
      tfr_pkg::MODE_FLIGHT:
        return s.in_digit_phase && s.run_length >= 3'd2 && s.run_length <= 3'd4;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Track the mode, predict each token verdict and compare results in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode = tfr_pkg::MODE_DIGITS;
      tok = tfr_pkg::TOK_CLEAR;
      verdict_due_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_due_q.size() == 0) begin
          report_mismatch($sformatf("result matched=%0b with nothing outstanding", matched_i));
        end else if (matched_i !== verdict_due_q[0]) begin
          report_mismatch($sformatf("matched=%0b, predicted %0b", matched_i,
                                    verdict_due_q[0]));
          void'(verdict_due_q.pop_front());
        end else begin
          void'(verdict_due_q.pop_front());
        end
      end
      if (cfg_we_i) begin
        cur_mode = cfg_wdata_i;
        tok = tfr_pkg::TOK_CLEAR;
      end
      if (in_valid_i && !in_stall_i) begin
        if (no_char_i) begin
          // drop a character-less request unless it closes the token
          if (last_char_i) begin
            verdict_due_q.push_back(1'b0);
            tok = tfr_pkg::TOK_CLEAR;
          end
        end else begin
          tok = scan_char(tok, cur_mode, char_code_i);
          if (last_char_i) begin
            verdict_due_q.push_back(token_matches(tok, cur_mode));
            tok = tfr_pkg::TOK_CLEAR;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o <= verdict_due_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
  localparam int         ITEM_TARGET       = 1950;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [tfr_pkg::ModeWidth-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic [7:0]                    char_code_i = 8'h00;
  logic                          last_char_i = 1'b0;
  logic                          no_char_i   = 1'b0;
  logic                          out_stall_i = 1'b0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic                          matched_o;

  int         fail_count;
  int         pending;
  int         gap_pct   = 25;
  int         stall_pct = 86;
  int         items_sent = 0;
  logic [7:0] tok_chars[$];

  token_format_recognizer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .last_char_i(last_char_i),
    .no_char_i  (no_char_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .matched_o  (matched_o)
  );

  tfr_match_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .no_char_i   (no_char_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .matched_i   (matched_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_upper();
    return "A" + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alpha();
    return $urandom_range(1) ? rand_upper() : "a" + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return $urandom_range(2) == 0 ? rand_digit() : rand_alpha();
  endfunction

  function automatic logic [7:0] rand_token_char();
    case ($urandom_range(3))
      0: return rand_digit();
      1: return tfr_pkg::CHAR_DOT;
      2: return tfr_pkg::CHAR_DASH;
      default: return rand_alpha();
    endcase
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(input logic [7:0] c, input logic lst, input logic nc);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= lst;
    no_char_i   <= nc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!nc || lst) items_sent++;
  endtask

  // Wait for the block to drain, then load a new pattern mode
  task automatic write_mode(input logic [2:0] m);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Build a mostly well-formed token for mode m, sometimes damaged
  task automatic compose_token(input logic [2:0] m);
    int v;
    int w;
    int p;
    int n_long;
    tok_chars.delete();
    case (m)
      tfr_pkg::MODE_DIGITS: begin
        repeat ($urandom_range(1, 6)) tok_chars.push_back(rand_digit());
      end
      tfr_pkg::MODE_IDENT: begin
        tok_chars.push_back(rand_alpha());
        repeat ($urandom_range(0, 6)) tok_chars.push_back(rand_alnum());
      end
      tfr_pkg::MODE_IPV4: begin
        for (int g = 0; g < 4; g++) begin
          v = ($urandom_range(99) < 85) ? $urandom_range(255) : $urandom_range(999, 256);
          w = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
          w = $urandom_range(3, w);
          if (w == 3) tok_chars.push_back("0" + 8'(v / 100));
          if (w >= 2) tok_chars.push_back("0" + 8'((v / 10) % 10));
          tok_chars.push_back("0" + 8'(v % 10));
          if (g < 3) tok_chars.push_back(tfr_pkg::CHAR_DOT);
        end
      end
      tfr_pkg::MODE_DATE: begin
        repeat (4) tok_chars.push_back(rand_digit());
        tok_chars.push_back(tfr_pkg::CHAR_DASH);
        repeat (2) tok_chars.push_back(rand_digit());
        tok_chars.push_back(tfr_pkg::CHAR_DASH);
        repeat (2) tok_chars.push_back(rand_digit());
      end
      tfr_pkg::MODE_FLIGHT: begin
        w = ($urandom_range(99) < 80) ? $urandom_range(2, 3) : $urandom_range(1, 4);
        repeat (w) tok_chars.push_back(rand_upper());
        w = ($urandom_range(99) < 80) ? $urandom_range(2, 4) : $urandom_range(1, 5);
        repeat (w) tok_chars.push_back(rand_digit());
      end
      default: begin
        repeat ($urandom_range(1, 5)) tok_chars.push_back(rand_alnum());
      end
    endcase
    if ($urandom_range(99) < 30) begin
      p = $urandom_range(tok_chars.size() - 1);
      n_long = $urandom_range(16, 20);
      case ($urandom_range(5))
        0: tok_chars[p] = 8'($urandom_range(255));
        1: if (tok_chars.size() > 1) tok_chars.delete(p);
        2: tok_chars.insert(p, rand_token_char());
        3: while (tok_chars.size() < n_long) tok_chars.push_back(rand_digit());
        4: tok_chars.push_back(tfr_pkg::CHAR_DOT);
        default: tok_chars.push_front($urandom_range(1) ? rand_digit() : rand_upper());
      endcase
    end
  endtask

  // Send one token; a few are empty or closed by a character-less request
  task automatic send_token(input logic [2:0] m);
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      send_request(8'($urandom_range(255)), 1'b1, 1'b1);
    end else begin
      compose_token(m);
      foreach (tok_chars[i]) begin
        if ($urandom_range(99) < 6) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
        send_request(tok_chars[i], (r >= 8) && (i == tok_chars.size() - 1), 1'b0);
      end
      if (r < 8) send_request(8'($urandom_range(255)), 1'b1, 1'b1);
    end
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], i == s.len() - 1, 1'b0);
  endtask

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [2:0] m;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, empty token and ignored request in the reset mode
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request("9", 1'b1, 1'b0);
    send_request(8'h5a, 1'b1, 1'b1);
    send_request("1", 1'b0, 1'b0);
    send_request(8'ha5, 1'b0, 1'b1);
    send_request("2", 1'b1, 1'b0);
    write_mode(tfr_pkg::MODE_IPV4);
    send_string("1.2.3.");
    send_string("255.0.9.10");
    write_mode(tfr_pkg::MODE_DATE);
    send_request("4", 1'b0, 1'b0);
    // abandon the open token with a mode change
    write_mode(tfr_pkg::MODE_FLIGHT);
    send_string("AB12");
    write_mode(MODE_UNUSED_LAST);
    send_request("a", 1'b1, 1'b0);
    write_mode(tfr_pkg::MODE_IDENT);
    send_string("x9");

    // Random rounds: pick a mode, then stream tokens
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        gap_pct   = 25;
        stall_pct = 86;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        gap_pct   = 86;
        stall_pct = 25;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      m = ($urandom_range(99) < 88) ? 3'($urandom_range(4))
                                     : 3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
      write_mode(m);
      repeat ($urandom_range(3, 12)) send_token(m);
      if ($urandom_range(99) < 8) begin
        compose_token(m);
        send_request(tok_chars[0], 1'b0, 1'b0);
      end
    end

    // Drain outstanding results and let the pipeline settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
